/* hdl/aoi_pkg.sv */
package aoi_pkg;

  localparam int CordicTabLen     = 24;
  localparam int CordicStagesDef  = 16;
  localparam int CordicIdxW       = 5;
  localparam int CordicW          = 34;
  localparam int DivNumW          = 52;
  localparam int DivDenW          = 28;
  localparam int DivCntW          = 6;

  localparam logic [31:0] CordicGain = 32'd652032874;
  localparam logic [31:0] HeadK      = 32'd2799883369;
  // ceil(2^30 / 125), exact quotient for dividends below 125 * 2^16
  localparam logic [23:0] Recip125   = 24'd8589935;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_QUERY = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [31:0]        now;
    logic signed [15:0] lin;
    logic signed [15:0] ang;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        h;
  } item_t;

  function automatic logic [29:0] atan_lut(input logic [CordicIdxW-1:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0:    r = 30'd536870912;
      5'd1:    r = 30'd316933406;
      5'd2:    r = 30'd167458907;
      5'd3:    r = 30'd85004756;
      5'd4:    r = 30'd42667331;
      5'd5:    r = 30'd21354465;
      5'd6:    r = 30'd10679838;
      5'd7:    r = 30'd5340245;
      5'd8:    r = 30'd2670163;
      5'd9:    r = 30'd1335087;
      5'd10:   r = 30'd667544;
      5'd11:   r = 30'd333772;
      5'd12:   r = 30'd166886;
      5'd13:   r = 30'd83443;
      5'd14:   r = 30'd41721;
      5'd15:   r = 30'd20861;
      5'd16:   r = 30'd10430;
      5'd17:   r = 30'd5215;
      5'd18:   r = 30'd2608;
      5'd19:   r = 30'd1304;
      5'd20:   r = 30'd652;
      5'd21:   r = 30'd326;
      5'd22:   r = 30'd163;
      5'd23:   r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/aoi_front.sv */
module aoi_front
  import aoi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         func_i,
  input  logic [31:0]        now_ms_i,
  input  logic signed [15:0] cmd_lin_vel_i,
  input  logic signed [15:0] cmd_ang_vel_i,
  input  logic signed [31:0] set_x_i,
  input  logic signed [31:0] set_y_i,
  input  logic signed [15:0] set_heading_i,
  output logic               deq_valid_o,
  input  logic               deq_ready_i,
  output item_t              deq_item_o
);

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;
  item_t      item;

  always_comb begin
    item.op  = op_e'(func_i);
    item.now = now_ms_i;
    item.lin = cmd_lin_vel_i;
    item.ang = cmd_ang_vel_i;
    item.x   = set_x_i;
    item.y   = set_y_i;
    item.h   = set_heading_i;
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign deq_valid_o = (count_q != 2'd0);
  assign deq_item_o  = mem_q[rd_ptr_q];
  // drop unused codes at the door
  assign push = in_valid_i && in_ready_o && (item.op != OP_NONE);
  assign pop  = deq_valid_o && deq_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

endmodule

/* hdl/aoi_cordic.sv */
module aoi_cordic
  import aoi_pkg::*;
#(
  parameter int STAGES = CordicStagesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [31:0]               phase_i,
  output logic                      done_o,
  output logic signed [CordicW-1:0] cos_o,
  output logic signed [CordicW-1:0] sin_o
);

  localparam int Iters = (STAGES < CordicTabLen) ? STAGES : CordicTabLen;
  localparam logic [CordicIdxW-1:0] LastIter = CordicIdxW'(Iters - 1);
  localparam logic signed [CordicW-1:0] Quarter = CordicW'(64'sd1073741824);
  localparam logic signed [CordicW-1:0] Half    = CordicW'(64'sd2147483648);

  logic signed [CordicW-1:0] x_q, y_q, a_q;
  logic                      flip_q, run_q, done_q;
  logic [CordicIdxW-1:0]     iter_q;
  logic signed [CordicW-1:0] a0, tx, ty, at;
  logic                      flip0;

  always_comb begin
    a0    = CordicW'($signed(phase_i));
    flip0 = 1'b0;
    if (a0 > Quarter) begin
      a0    = a0 - Half;
      flip0 = 1'b1;
    end else if (a0 < -Quarter) begin
      a0    = a0 + Half;
      flip0 = 1'b1;
    end
    tx = y_q >>> iter_q;
    ty = x_q >>> iter_q;
    at = $signed({4'b0, atan_lut(iter_q)});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      a_q    <= '0;
      flip_q <= 1'b0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        x_q    <= $signed({2'b0, CordicGain});
        y_q    <= '0;
        a_q    <= a0;
        flip_q <= flip0;
        iter_q <= '0;
        run_q  <= 1'b1;
      end else if (run_q) begin
        if (!a_q[CordicW-1]) begin
          x_q <= x_q - tx;
          y_q <= y_q + ty;
          a_q <= a_q - at;
        end else begin
          x_q <= x_q + tx;
          y_q <= y_q - ty;
          a_q <= a_q + at;
        end
        iter_q <= iter_q + 1'b1;
        if (iter_q == LastIter) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;

endmodule

/* hdl/aoi_div.sv */
module aoi_div
  import aoi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [DivDenW-1:0] den_i,
  output logic               done_o,
  output logic [DivNumW-1:0] quo_o
);

  localparam logic [DivCntW-1:0] LastCnt = DivCntW'(DivNumW - 1);

  logic [DivNumW-1:0] q_q;
  logic [DivDenW-1:0] rem_q, den_q;
  logic [DivCntW-1:0] cnt_q;
  logic               run_q, done_q;
  logic [DivDenW:0]   r2;
  logic               ge;

  assign r2 = {rem_q, q_q[DivNumW-1]};
  assign ge = (r2 >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q    <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        q_q   <= num_i;
        den_q <= den_i;
        rem_q <= '0;
        cnt_q <= '0;
        run_q <= 1'b1;
      end else if (run_q) begin
        rem_q <= ge ? DivDenW'(r2 - {1'b0, den_q}) : DivDenW'(r2);
        q_q   <= {q_q[DivNumW-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = q_q;

endmodule

/* hdl/arc_odometry_integrator.sv */
// From input accept: a reset-pose item updates the pose as the back end takes it from the
// queue; a straight move runs one CORDIC run, a 4-step divide by 125 and two 3-step
// multiplies; an arc move runs two CORDIC runs and two divides. A query also waits on a
// held result.
// Throughput: one item at a time in the back end; a two-entry queue takes new items.
// Reset (rst_ni low, asynchronous): pose, command, last time and queue clear to zero.
module arc_odometry_integrator
  import aoi_pkg::*;
#(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         func_i,
  input  logic [31:0]        now_ms_i,
  input  logic signed [15:0] cmd_lin_vel_i,
  input  logic signed [15:0] cmd_ang_vel_i,
  input  logic signed [31:0] set_x_i,
  input  logic signed [31:0] set_y_i,
  input  logic signed [15:0] set_heading_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [15:0] heading_o,
  output logic signed [15:0] lin_vel_o,
  output logic signed [15:0] ang_vel_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_PREP, ST_C0, ST_DIST_GO, ST_DIST, ST_MUL_LO, ST_MUL_HI, ST_MUL_SUM,
    ST_HK_LO, ST_HK_HI, ST_HK_SUM, ST_C1_GO, ST_C1, ST_ARC_MUL, ST_ARC_GO, ST_ARC_DIV,
    ST_FINISH
  } st_e;

  st_e                       state_q;
  logic                      deq_valid, deq_ready;
  item_t                     deq_item, item_q;

  logic signed [31:0]        pose_x_q, pose_y_q;
  logic [15:0]               pose_h_q, hnew_q;
  logic signed [15:0]        lin_q, ang_q;
  logic [31:0]               last_q, d_q;
  logic [47:0]               vdt_q;
  logic signed [47:0]        prodw_q;
  logic signed [CordicW-1:0] c0_q, s0_q, c1_q, s1_q;
  logic [43:0]               dist_q;
  logic [63:0]               dn_q;
  logic [6:0]                drem_q;
  logic [1:0]                dcnt_q;
  logic [53:0]               pp_lo_q, pp_hi_q;
  logic [59:0]               hk_lo_q;
  logic [27:0]               hk_hi_q;
  logic signed [50:0]        arcn_q;
  logic signed [45:0]        dx_q, dy_q;
  logic                      sel_q;

  logic                      out_valid_q;
  logic signed [31:0]        out_x_q, out_y_q;
  logic [15:0]               out_h_q;
  logic signed [15:0]        out_lin_q, out_ang_q;

  logic                      cor_start, cor_done;
  logic [31:0]               cor_phase;
  logic signed [CordicW-1:0] cor_cos, cor_sin;
  logic                      div_start, div_done;
  logic [DivNumW-1:0]        div_num, div_quo;
  logic [DivDenW-1:0]        div_den;

  logic [31:0]               dt;
  logic [15:0]               vmag, wmag;
  logic signed [CordicW-1:0] trig;
  logic [31:0]               tmag;
  logic [75:0]               msum;
  logic signed [45:0]        mval, qval;
  logic signed [55:0]        p56;
  logic [59:0]               hk_full;
  logic [55:0]               hsum;
  logic [31:0]               dsum;
  logic signed [34:0]        diff;
  logic [50:0]               un;
  logic [27:0]               ud;
  logic                      arc_neg;
  logic [22:0]               dtop;
  logic [46:0]               dprod;
  logic [15:0]               dq_dig;
  logic [6:0]                drem_nx;
  logic signed [31:0]        fin_x, fin_y;
  logic [15:0]               fin_h;
  logic                      out_free;
  logic                      out_load;

  function automatic logic signed [31:0] sat32(input logic signed [31:0] a,
                                               input logic signed [45:0] b);
    logic signed [46:0] s;
    s = 47'(a) + 47'(b);
    if (s > 47'sd2147483647)       return 32'sh7fffffff;
    else if (s < -47'sd2147483648) return 32'sh80000000;
    else                           return s[31:0];
  endfunction

  aoi_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .now_ms_i,
    .cmd_lin_vel_i, .cmd_ang_vel_i, .set_x_i, .set_y_i, .set_heading_i,
    .deq_valid_o (deq_valid),
    .deq_ready_i (deq_ready),
    .deq_item_o  (deq_item)
  );

  aoi_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk_i, .rst_ni,
    .start_i (cor_start),
    .phase_i (cor_phase),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  aoi_div u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    dt        = item_q.now - last_q;
    vmag      = 16'(lin_q[15] ? -lin_q : lin_q);
    wmag      = 16'(ang_q[15] ? -ang_q : ang_q);
    trig      = sel_q ? c0_q : s0_q;
    tmag      = 32'(trig[CordicW-1] ? -trig : trig);
    msum      = {pp_hi_q, 22'b0} + 76'(pp_lo_q) + 76'(32'd536870912);
    mval      = $signed(msum[75:30]);
    p56       = 56'(prodw_q);
    hk_full   = 60'(p56[55:28]) * 60'(HeadK);
    hsum      = 56'(hk_lo_q) + {hk_hi_q, 28'b0} + 56'(32'd8388608);
    dsum      = d_q + 32'h8000;
    diff      = sel_q ? 35'(s1_q) - 35'(s0_q) : 35'(c1_q) - 35'(c0_q);
    un        = arcn_q[50] ? 51'(-arcn_q) : 51'(arcn_q);
    ud        = {wmag, 12'b0};
    arc_neg   = arcn_q[50] != ang_q[15];
    qval      = $signed(div_quo[45:0]);
    dtop      = {drem_q, dn_q[63:48]};
    dprod     = 47'(dtop) * 47'(Recip125);
    dq_dig    = dprod[45:30];
    drem_nx   = 7'(dtop - 23'(dq_dig) * 23'd125);
    cor_start = (state_q == ST_PREP) || (state_q == ST_C1_GO);
    cor_phase = (state_q == ST_PREP) ? {pose_h_q, 16'b0} : {pose_h_q, 16'b0} + d_q;
    div_start = (state_q == ST_ARC_GO);
    div_num   = 52'(un) + 52'(ud[27:1]);
    div_den   = ud;
    fin_x     = sat32(pose_x_q, dx_q);
    fin_y     = sat32(pose_y_q, dy_q);
    fin_h     = (ang_q == 16'sd0) ? pose_h_q : hnew_q;
    out_free  = !out_valid_q || out_ready_i;
    out_load  = (state_q == ST_FINISH) && (item_q.op == OP_QUERY) && out_free;
    deq_ready = (state_q == ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      item_q      <= '0;
      pose_x_q    <= '0;
      pose_y_q    <= '0;
      pose_h_q    <= '0;
      lin_q       <= '0;
      ang_q       <= '0;
      last_q      <= '0;
      hnew_q      <= '0;
      d_q         <= '0;
      vdt_q       <= '0;
      prodw_q     <= '0;
      c0_q        <= '0;
      s0_q        <= '0;
      c1_q        <= '0;
      s1_q        <= '0;
      dist_q      <= '0;
      dn_q        <= '0;
      drem_q      <= '0;
      dcnt_q      <= '0;
      pp_lo_q     <= '0;
      pp_hi_q     <= '0;
      hk_lo_q     <= '0;
      hk_hi_q     <= '0;
      arcn_q      <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_h_q     <= '0;
      out_lin_q   <= '0;
      out_ang_q   <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !out_load) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (deq_valid) begin
            item_q <= deq_item;
            if (deq_item.op == OP_LOAD) begin
              pose_x_q <= deq_item.x;
              pose_y_q <= deq_item.y;
              pose_h_q <= deq_item.h;
              last_q   <= deq_item.now;
            end else begin
              state_q <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          vdt_q   <= 48'(vmag) * 48'(dt);
          prodw_q <= 48'(ang_q) * $signed({16'b0, dt});
          state_q <= ST_C0;
        end
        ST_C0: begin
          if (cor_done) begin
            c0_q    <= cor_cos;
            s0_q    <= cor_sin;
            state_q <= (ang_q == 16'sd0) ? ST_DIST_GO : ST_HK_LO;
          end
        end
        ST_DIST_GO: begin
          dn_q    <= 64'({vdt_q, 3'b0}) + 64'd62;
          drem_q  <= '0;
          dcnt_q  <= '0;
          state_q <= ST_DIST;
        end
        ST_DIST: begin
          dn_q   <= {dn_q[47:0], dq_dig};
          drem_q <= drem_nx;
          dcnt_q <= dcnt_q + 2'd1;
          if (dcnt_q == 2'd3) begin
            dist_q  <= {dn_q[27:0], dq_dig};
            sel_q   <= 1'b0;
            state_q <= ST_MUL_LO;
          end
        end
        ST_MUL_LO: begin
          pp_lo_q <= 54'(dist_q[21:0]) * 54'(tmag);
          state_q <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          pp_hi_q <= 54'(dist_q[43:22]) * 54'(tmag);
          state_q <= ST_MUL_SUM;
        end
        ST_MUL_SUM: begin
          if (!sel_q) begin
            dx_q    <= (lin_q[15] != s0_q[CordicW-1]) ? mval : -mval;
            sel_q   <= 1'b1;
            state_q <= ST_MUL_LO;
          end else begin
            dy_q    <= (lin_q[15] != c0_q[CordicW-1]) ? -mval : mval;
            state_q <= ST_FINISH;
          end
        end
        ST_HK_LO: begin
          hk_lo_q <= 60'(prodw_q[27:0]) * 60'(HeadK);
          state_q <= ST_HK_HI;
        end
        ST_HK_HI: begin
          hk_hi_q <= hk_full[27:0];
          state_q <= ST_HK_SUM;
        end
        ST_HK_SUM: begin
          d_q     <= hsum[55:24];
          state_q <= ST_C1_GO;
        end
        ST_C1_GO: begin
          hnew_q  <= pose_h_q + dsum[31:16];
          state_q <= ST_C1;
        end
        ST_C1: begin
          if (cor_done) begin
            c1_q    <= cor_cos;
            s1_q    <= cor_sin;
            sel_q   <= 1'b0;
            state_q <= ST_ARC_MUL;
          end
        end
        ST_ARC_MUL: begin
          arcn_q  <= 51'(lin_q) * 51'(diff);
          state_q <= ST_ARC_GO;
        end
        ST_ARC_GO: state_q <= ST_ARC_DIV;
        ST_ARC_DIV: begin
          if (div_done) begin
            if (!sel_q) begin
              dx_q    <= arc_neg ? -qval : qval;
              sel_q   <= 1'b1;
              state_q <= ST_ARC_MUL;
            end else begin
              dy_q    <= arc_neg ? -qval : qval;
              state_q <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (item_q.op == OP_SET) begin
            pose_x_q <= fin_x;
            pose_y_q <= fin_y;
            pose_h_q <= fin_h;
            last_q   <= item_q.now;
            lin_q    <= item_q.lin;
            ang_q    <= item_q.ang;
            state_q  <= ST_IDLE;
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            out_x_q     <= fin_x;
            out_y_q     <= fin_y;
            out_h_q     <= fin_h;
            out_lin_q   <= lin_q;
            out_ang_q   <= ang_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_x_q;
  assign pos_y_o     = out_y_q;
  assign heading_o   = out_h_q;
  assign lin_vel_o   = out_lin_q;
  assign ang_vel_o   = out_ang_q;

`ifndef SYNTHESIS
  a_cor_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_done |-> (state_q == ST_C0 || state_q == ST_C1))
    else $error("cordic result with no state waiting");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIST || state_q == ST_ARC_DIV))
    else $error("divider result with no state waiting");

  a_load_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && deq_valid && deq_item.op == OP_LOAD)
      |=> last_q == $past(deq_item.now))
    else $error("reset pose did not store time");

  a_query_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && item_q.op == OP_QUERY && out_free) |=> out_valid_q)
    else $error("query finished without result");

  a_set_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && item_q.op == OP_SET && !out_valid_q) |=> !out_valid_q)
    else $error("set command produced a result");
`endif

endmodule

/* test/tb.sv */
module tb;
  import aoi_pkg::*;

  localparam longint Two30 = 64'sd1073741824;
  localparam longint Two31 = 64'sd2147483648;
  localparam longint Two32 = 64'sd4294967296;

  typedef struct {
    op_e         op;
    logic [31:0] now;
    logic [15:0] lin;
    logic [15:0] ang;
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] h;
    bit          drain;
  } cmd_item_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] h;
    logic [15:0] lin;
    logic [15:0] ang;
  } pose_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] func_i = '0;
  logic [31:0] now_ms_i = '0;
  logic signed [15:0] cmd_lin_vel_i = '0;
  logic signed [15:0] cmd_ang_vel_i = '0;
  logic signed [31:0] set_x_i = '0;
  logic signed [31:0] set_y_i = '0;
  logic signed [15:0] set_heading_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] pos_x_o;
  logic signed [31:0] pos_y_o;
  logic signed [15:0] heading_o;
  logic signed [15:0] lin_vel_o;
  logic signed [15:0] ang_vel_o;

  arc_odometry_integrator u_dut (.*);

  cmd_item_t pending_q[$];
  pose_t     pose_exp_q[$];
  int unsigned mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  bit          stim_done = 1'b0;

  logic signed [31:0] mdl_x, mdl_y;
  logic [15:0]        mdl_h;
  logic signed [15:0] mdl_lin, mdl_ang;
  logic [31:0]        mdl_time;

  initial forever #6 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic cordic_rot(input logic [31:0] ph, output longint c, output longint s);
    longint a, x, y, tx, ty;
    bit flip;
    a = longint'(ph);
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (a >= Two31) a -= Two32;
    if (a > Two30) begin
      a -= Two31;
      flip = 1'b1;
    end else if (a < -Two30) begin
      a += Two31;
      flip = 1'b1;
    end
    for (int i = 0; i < CordicStagesDef && i < CordicTabLen; i++) begin
      tx = y >>> i;
      ty = x >>> i;
      if (a >= 0) begin
        x -= tx; y += ty; a -= longint'(atan_lut(i[4:0]));
      end else begin
        x += tx; y -= ty; a += longint'(atan_lut(i[4:0]));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint round_div(longint n, longint d);
    longint un, ud, r;
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    r = (un + ud / 2) / ud;
    return ((n < 0) != (d < 0)) ? -r : r;
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  task automatic project_pose(input logic [31:0] now, output pose_t p);
    logic [31:0] dt, d, ph1;
    logic [63:0] prod, hp;
    logic [127:0] wide;
    longint v, w, dx, dy, c0, s0, c1, s1, mx, my, ms, mc;
    longint unsigned travel, vm;
    dt = now - mdl_time;
    v = longint'(mdl_lin);
    w = longint'(mdl_ang);
    p.h = mdl_h;
    cordic_rot({mdl_h, 16'h0}, c0, s0);
    if (w == 0) begin
      vm = v < 0 ? -v : v;
      travel = (vm * longint'(dt) * 8 + 62) / 125;
      ms = s0 < 0 ? -s0 : s0;
      mc = c0 < 0 ? -c0 : c0;
      wide = 128'(travel) * 128'(ms) + (128'd1 << 29);
      mx = longint'(wide >> 30);
      wide = 128'(travel) * 128'(mc) + (128'd1 << 29);
      my = longint'(wide >> 30);
      dx = ((v < 0) != (s0 < 0)) ? mx : -mx;
      dy = ((v < 0) != (c0 < 0)) ? -my : my;
    end else begin
      prod = w * longint'(dt);
      hp = prod * 64'(HeadK) + (64'd1 << 23);
      d = hp[55:24];
      ph1 = {mdl_h, 16'h0} + d;
      cordic_rot(ph1, c1, s1);
      dx = round_div(v * (c1 - c0), w * 4096);
      dy = round_div(v * (s1 - s0), w * 4096);
      hp[31:0] = d + 32'h8000;
      p.h = mdl_h + hp[31:16];
    end
    p.x = sat32(longint'(mdl_x) + dx);
    p.y = sat32(longint'(mdl_y) + dy);
    p.lin = mdl_lin;
    p.ang = mdl_ang;
  endtask

  task automatic predict_item(input cmd_item_t it);
    pose_t p;
    case (it.op)
      OP_SET: begin
        project_pose(it.now, p);
        mdl_x = p.x; mdl_y = p.y; mdl_h = p.h;
        mdl_time = it.now;
        mdl_lin = it.lin; mdl_ang = it.ang;
      end
      OP_QUERY: begin
        project_pose(it.now, p);
        pose_exp_q.push_back(p);
      end
      OP_LOAD: begin
        mdl_x = it.x; mdl_y = it.y; mdl_h = it.h;
        mdl_time = it.now;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mdl_x = '0; mdl_y = '0; mdl_h = '0;
      mdl_lin = '0; mdl_ang = '0; mdl_time = '0;
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_item('{op: op_e'(func_i), now: now_ms_i, lin: cmd_lin_vel_i,
                       ang: cmd_ang_vel_i, x: set_x_i, y: set_y_i,
                       h: set_heading_i, drain: 1'b0});
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0 &&
                     !(pending_q[0].drain && pose_exp_q.size() > 0)) begin
          func_i <= pending_q[0].op;
          now_ms_i <= pending_q[0].now;
          cmd_lin_vel_i <= pending_q[0].lin;
          cmd_ang_vel_i <= pending_q[0].ang;
          set_x_i <= pending_q[0].x;
          set_y_i <= pending_q[0].y;
          set_heading_i <= pending_q[0].h;
          in_valid_i <= 1'b1;
          void'(pending_q.pop_front());
          send_gap <= pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pose_exp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result x=%h y=%h", pos_x_o, pos_y_o);
        end else begin
          if (pos_x_o !== pose_exp_q[0].x || pos_y_o !== pose_exp_q[0].y ||
              heading_o !== pose_exp_q[0].h || lin_vel_o !== pose_exp_q[0].lin ||
              ang_vel_o !== pose_exp_q[0].ang) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp x=%h y=%h h=%h l=%h a=%h got x=%h y=%h h=%h l=%h a=%h",
                       pose_exp_q[0].x, pose_exp_q[0].y, pose_exp_q[0].h,
                       pose_exp_q[0].lin, pose_exp_q[0].ang, pos_x_o, pos_y_o,
                       heading_o, lin_vel_o, ang_vel_o);
          end
          void'(pose_exp_q.pop_front());
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
      end
    end
  end

  task automatic add_item(op_e op, logic [31:0] now, logic [15:0] lin, logic [15:0] ang,
                          logic [31:0] x, logic [31:0] y, logic [15:0] h, bit drain);
    pending_q.push_back('{op: op, now: now, lin: lin, ang: ang, x: x, y: y, h: h,
                          drain: drain});
  endtask

  initial begin
    logic [31:0] t;
    int unsigned r;
    logic [15:0] ang;
    logic [31:0] px, py;
    add_item(OP_QUERY, 32'd0, '0, '0, '0, '0, '0, 1'b0);
    add_item(OP_QUERY, 32'd500, 16'hffff, 16'hffff, '1, '1, '1, 1'b0);
    add_item(OP_SET, 32'd1000, 16'h7fff, 16'h0000, '0, '0, '0, 1'b0);
    add_item(OP_QUERY, 32'd1100, '0, '0, '0, '0, '0, 1'b0);
    add_item(OP_SET, 32'd1200, 16'h8000, 16'h8000, '0, '0, '0, 1'b0);
    add_item(OP_QUERY, 32'd1250, '0, '0, '0, '0, '0, 1'b0);
    add_item(OP_QUERY, 32'd1250, '0, '0, '0, '0, '0, 1'b0);
    add_item(OP_NONE, 32'hffffffff, 16'h1234, 16'h4321, '1, '1, '1, 1'b0);
    add_item(OP_QUERY, 32'd1300, '0, '0, '0, '0, '0, 1'b0);
    add_item(OP_LOAD, 32'd2000, '0, '0, 32'h7fffffff, 32'h80000000, 16'h8000, 1'b0);
    add_item(OP_SET, 32'd2010, 16'h7fff, 16'h7fff, '0, '0, '0, 1'b0);
    add_item(OP_QUERY, 32'd2500, '0, '0, '0, '0, '0, 1'b0);
    add_item(OP_QUERY, 32'd100, '0, '0, '0, '0, '0, 1'b0);
    add_item(OP_LOAD, 32'd3000, '0, '0, 32'h80000000, 32'h7fffffff, 16'h7fff, 1'b0);
    add_item(OP_SET, 32'd3000, 16'h0400, 16'h0000, '0, '0, '0, 1'b0);
    add_item(OP_QUERY, 32'hffffffff, '0, '0, '0, '0, '0, 1'b0);
    add_item(OP_SET, 32'd4000, 16'hfc00, 16'h1000, '0, '0, '0, 1'b0);
    add_item(OP_QUERY, 32'd4300, '0, '0, '0, '0, '0, 1'b1);
    add_item(OP_LOAD, 32'd5000, '0, '0, '0, '0, '0, 1'b0);
    add_item(OP_QUERY, 32'd5000, '0, '0, '0, '0, '0, 1'b0);
    t = 32'd6000;
    for (int n = 0; n < 1600; n++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0) t = $urandom();
      else t = t + $urandom_range(0, 300);
      ang = 16'($urandom());
      if ($urandom_range(0, 3) == 0) ang = '0;
      else if ($urandom_range(0, 2) == 0) ang = 16'($urandom_range(0, 2047) - 1024);
      px = $urandom();
      py = $urandom();
      if ($urandom_range(0, 3) != 0) begin
        px = $urandom_range(0, 32'h01ffffff) - 32'h01000000;
        py = $urandom_range(0, 32'h01ffffff) - 32'h01000000;
      end
      if (r < 35)
        add_item(OP_SET, t, 16'($urandom()), ang, $urandom(), $urandom(),
                 16'($urandom()), 1'b0);
      else if (r < 80)
        add_item(OP_QUERY, t, 16'($urandom()), 16'($urandom()), $urandom(), $urandom(),
                 16'($urandom()), (n % 400) == 399);
      else if (r < 95)
        add_item(OP_LOAD, t, 16'($urandom()), 16'($urandom()), px, py,
                 16'($urandom()), 1'b0);
      else
        add_item(OP_NONE, $urandom(), 16'($urandom()), 16'($urandom()), $urandom(),
                 $urandom(), 16'($urandom()), 1'b0);
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0);
    @(posedge clk_i);
    while (in_valid_i || pose_exp_q.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && pose_exp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
